@@ rtl/ile_pkg.sv @@
// Shared types, opcodes and codes for the indexed list engine.
package ile_pkg;

  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 7;
  localparam int DATA_W     = 32;
  localparam int FOUND_W    = 6;
  localparam int COUNT_W    = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_SET      = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_GET      = 3'd4,
    OP_INDEX_OF = 3'd5,
    OP_CONTAINS = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [POSITION_W-1:0]    position;
    logic signed [DATA_W-1:0] data_in;
  } request_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic [FOUND_W-1:0]       found_position;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_UP,
    S_WRITE,
    S_READ,
    S_TAKE,
    S_SHIFT_DN,
    S_SCAN,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_STEP_UP,
    CMD_STEP_DN,
    CMD_STEP_SCAN,
    CMD_READ_POS,
    CMD_TAKE,
    CMD_WRITE_POS,
    CMD_FINISH
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ok;
    logic up_more;
    logic dn_more;
    logic scan_more;
  } dp_status_t;

endpackage

@@ rtl/indexed_list_engine_unit.sv @@
// Top level of the indexed list engine: controller plus datapath.
//
//  channel   ports                     handshake
//  --------  ------------------------  ---------------------------------------
//  item in   request (request_t)       taken when start is high and busy low
//  result    result (result_t)         valid for one cycle while done is high
//
// Busy time per item depends on the walk over the list memory, one entry per cycle through
// its single read and single write port: insert and remove walk the entries from the
// position to the end of the list, index_of and contains walk the whole list, and
// append, set, get, clear or a failed check walk none.
// The result strobe is high in the first cycle with busy low; the next item is taken
// at the earliest at the edge that ends that cycle.
// Reset clears the count and the controller; list entries are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_list_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ile_pkg::request_t request,
  output logic              done,
  output ile_pkg::result_t  result
);

  ile_pkg::dp_cmd_t    cmd;
  ile_pkg::dp_status_t status;

  ile_controller u_ctl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  ile_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .status  (status),
    .result  (result)
  );

endmodule

@@ rtl/ile_datapath.sv @@
// Datapath: list memory, walk pointer, entry count and result register.
module ile_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ile_pkg::dp_cmd_t    cmd,
  input  ile_pkg::request_t   request,
  output ile_pkg::dp_status_t status,
  output ile_pkg::result_t    result
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ile_pkg::POSITION_W) ? CW : ile_pkg::POSITION_W;
  localparam int FPW  = (AW > ile_pkg::FOUND_W) ? AW : ile_pkg::FOUND_W;
  localparam int DW   = ile_pkg::DATA_W;

  logic [DW-1:0]   mem [CAPACITY];

  ile_pkg::op_t    op_q;
  logic [CMPW-1:0] pos_q;
  logic [DW-1:0]   val_q;
  logic            ok_q;
  logic [DW-1:0]   dout_q;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   idx;
  logic            pend;
  logic [AW-1:0]   pend_dst;
  logic            found;
  logic [AW-1:0]   found_idx;
  logic [DW-1:0]   rd_data;

  ile_pkg::op_t    req_op;
  logic [CMPW-1:0] req_pos;
  logic [CMPW-1:0] count_ext;
  logic            has_room;
  logic            req_ok;
  logic            is_search;
  logic            is_step;
  logic            hit;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;
  logic [CMPW-1:0] count_next_ext;
  logic [FPW-1:0]  found_ext;

  assign req_op    = ile_pkg::op_t'(request.opcode);
  assign req_pos   = CMPW'(request.position);
  assign count_ext = CMPW'(count);
  assign has_room  = count < CW'(CAPACITY);
  assign is_search = (op_q == ile_pkg::OP_INDEX_OF) || (op_q == ile_pkg::OP_CONTAINS);
  assign is_step   = (cmd == ile_pkg::CMD_STEP_UP) || (cmd == ile_pkg::CMD_STEP_DN) ||
                     (cmd == ile_pkg::CMD_STEP_SCAN);
  assign hit       = pend && is_search && (rd_data == val_q) && !found;

  // Check the item against the list before any work starts
  always_comb begin
    unique case (req_op) inside
      ile_pkg::OP_APPEND: req_ok = has_room;
      ile_pkg::OP_INSERT: req_ok = has_room && (req_pos <= count_ext);
      ile_pkg::OP_SET, ile_pkg::OP_REMOVE, ile_pkg::OP_GET: req_ok = req_pos < count_ext;
      default: req_ok = 1'b1;
    endcase
  end

  // Report walk progress to the controller
  always_comb begin
    status.op        = op_q;
    status.ok        = ok_q;
    status.up_more   = CMPW'(idx) > pos_q;
    status.dn_more   = (idx + CW'(1)) < count;
    status.scan_more = idx < count;
  end

  // Select the read address for the current step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (cmd)
      ile_pkg::CMD_STEP_UP: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx - CW'(1));
      end
      ile_pkg::CMD_STEP_DN: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx + CW'(1));
      end
      ile_pkg::CMD_STEP_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx);
      end
      ile_pkg::CMD_READ_POS: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos_q);
      end
      default: ;
    endcase
  end

  // Write back a shifted entry, or the item's value at its position
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_dst;
    wr_data = rd_data;
    if (pend && !is_search) begin
      wr_en = 1'b1;
    end else if (cmd == ile_pkg::CMD_WRITE_POS) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_q);
      wr_data = val_q;
    end
  end

  // List memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Work out the count after the item
  always_comb begin
    count_next = count;
    if (cmd == ile_pkg::CMD_FINISH) begin
      case (op_q) inside
        ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: begin
          if (ok_q) count_next = count + CW'(1);
        end
        ile_pkg::OP_REMOVE: begin
          if (ok_q) count_next = count - CW'(1);
        end
        ile_pkg::OP_CLEAR: count_next = '0;
        default: ;
      endcase
    end
  end

  assign count_next_ext = CMPW'(count_next);
  assign found_ext      = FPW'(found_idx);

  // Control state: count, pending step and search hit
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      count <= count_next;
      pend  <= is_step;
      if (cmd == ile_pkg::CMD_CAPTURE) begin
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
    end
  end

  // Payload registers of the item under work and its result
  always_ff @(posedge clk) begin
    if (is_step) begin
      pend_dst <= AW'(idx);
    end
    if (hit) begin
      found_idx <= pend_dst;
    end
    case (cmd)
      ile_pkg::CMD_CAPTURE: begin
        op_q   <= req_op;
        pos_q  <= (req_op == ile_pkg::OP_APPEND) ? count_ext : req_pos;
        val_q  <= request.data_in;
        ok_q   <= req_ok;
        dout_q <= '0;
        case (req_op) inside
          ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: idx <= count;
          ile_pkg::OP_INDEX_OF, ile_pkg::OP_CONTAINS: idx <= '0;
          default: idx <= CW'(req_pos);
        endcase
      end
      ile_pkg::CMD_STEP_UP:   idx <= idx - CW'(1);
      ile_pkg::CMD_STEP_DN:   idx <= idx + CW'(1);
      ile_pkg::CMD_STEP_SCAN: idx <= idx + CW'(1);
      ile_pkg::CMD_TAKE:      dout_q <= rd_data;
      ile_pkg::CMD_FINISH: begin
        result.ok             <= is_search ? found : ok_q;
        result.data_out       <= dout_q;
        result.found_position <= (op_q == ile_pkg::OP_INDEX_OF && found) ?
                                 found_ext[ile_pkg::FOUND_W-1:0] : '0;
        result.entry_count    <= count_next_ext[ile_pkg::COUNT_W-1:0];
        result.is_empty       <= (count_next == '0);
      end
      default: ;
    endcase
  end

  // Count stays within the list's room
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A shifted entry write never meets a value write in the same cycle
  a_write_port: assert property (@(posedge clk) disable iff (rst)
    !(pend && !is_search && cmd == ile_pkg::CMD_WRITE_POS))
    else $error("write port collision");

  // A good append or insert grows the list by one
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd == ile_pkg::CMD_FINISH && ok_q &&
     (op_q == ile_pkg::OP_APPEND || op_q == ile_pkg::OP_INSERT))
    |=> count == $past(count) + CW'(1))
    else $error("count did not grow after insert");

endmodule

@@ rtl/ile_controller.sv @@
// Controller: sequences each item's steps over the datapath.
module ile_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  ile_pkg::dp_status_t status,
  output ile_pkg::dp_cmd_t    cmd
);

  ile_pkg::ctl_state_t state;
  ile_pkg::ctl_state_t state_next;

  assign busy = (state != ile_pkg::S_IDLE);

  // State register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ile_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ile_pkg::S_FINISH);
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd        = ile_pkg::CMD_NONE;
    unique case (state)
      ile_pkg::S_IDLE: begin
        if (start) begin
          cmd        = ile_pkg::CMD_CAPTURE;
          state_next = ile_pkg::S_DISPATCH;
        end
      end
      ile_pkg::S_DISPATCH: begin
        unique case (status.op) inside
          ile_pkg::OP_INDEX_OF, ile_pkg::OP_CONTAINS: state_next = ile_pkg::S_SCAN;
          ile_pkg::OP_CLEAR: state_next = ile_pkg::S_FINISH;
          ile_pkg::OP_APPEND, ile_pkg::OP_INSERT:
            state_next = status.ok ? ile_pkg::S_SHIFT_UP : ile_pkg::S_FINISH;
          ile_pkg::OP_SET:
            state_next = status.ok ? ile_pkg::S_WRITE : ile_pkg::S_FINISH;
          default:
            state_next = status.ok ? ile_pkg::S_READ : ile_pkg::S_FINISH;
        endcase
      end
      ile_pkg::S_SHIFT_UP: begin
        if (status.up_more) begin
          cmd = ile_pkg::CMD_STEP_UP;
        end else begin
          state_next = ile_pkg::S_WRITE;
        end
      end
      ile_pkg::S_WRITE: begin
        cmd        = ile_pkg::CMD_WRITE_POS;
        state_next = ile_pkg::S_FINISH;
      end
      ile_pkg::S_READ: begin
        cmd        = ile_pkg::CMD_READ_POS;
        state_next = ile_pkg::S_TAKE;
      end
      ile_pkg::S_TAKE: begin
        cmd        = ile_pkg::CMD_TAKE;
        state_next = (status.op == ile_pkg::OP_REMOVE) ? ile_pkg::S_SHIFT_DN :
                     ile_pkg::S_FINISH;
      end
      ile_pkg::S_SHIFT_DN: begin
        if (status.dn_more) begin
          cmd = ile_pkg::CMD_STEP_DN;
        end else begin
          state_next = ile_pkg::S_FINISH;
        end
      end
      ile_pkg::S_SCAN: begin
        if (status.scan_more) begin
          cmd = ile_pkg::CMD_STEP_SCAN;
        end else begin
          state_next = ile_pkg::S_FINISH;
        end
      end
      ile_pkg::S_FINISH: begin
        cmd        = ile_pkg::CMD_FINISH;
        state_next = ile_pkg::S_IDLE;
      end
      default: state_next = ile_pkg::S_IDLE;
    endcase
  end

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // A result shows only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Work starts only from an accepted item
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(busy) |-> $past(start))
    else $error("busy without start");

endmodule
